>>> rtl/sacc_pkg.sv
package sacc_pkg;

    // Build-time defaults for the top-level parameters
    localparam int MAX_WAYS_DEF = 8;
    localparam int MAX_SETS_DEF = 256;

    // Address bits that take part in an access
    localparam int ADDR_BITS = 32;
    localparam int ADDR_W    = 32;
    localparam int TAG_W     = 32;
    localparam int AGE_W     = 64;
    localparam int CNT_W     = 12;

    localparam logic [4:0] MAX_OFFSET_BITS = 5'd24;
    localparam logic [15:0] LFSR_SEED      = 16'hACE1;

    // Function codes of an input transaction
    localparam logic [1:0] FUNC_READ  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_FLUSH = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_WRITE_POLICY   = 3'd0;
    localparam logic [2:0] CFG_REPLACE_POLICY = 3'd1;
    localparam logic [2:0] CFG_OFFSET_BITS    = 3'd2;
    localparam logic [2:0] CFG_SET_BITS       = 3'd3;
    localparam logic [2:0] CFG_WAYS_IN_USE    = 3'd4;

    typedef struct packed {
        logic             valid;
        logic             dirty;
        logic [TAG_W-1:0] tag;
        logic [AGE_W-1:0] age;
    } line_t;

    // Right-shifting LFSR, taps 16,14,13,11
    function automatic logic [15:0] lfsr_next(input logic [15:0] v);
        logic fb;
        fb = v[0] ^ v[2] ^ v[3] ^ v[5];
        return {fb, v[15:1]};
    endfunction

endpackage

>>> rtl/sacc_ram.sv
module sacc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/sacc_mod.sv
module sacc_mod #(
    parameter int DIV_W = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [15:0]      dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] rem
);

    logic [DIV_W:0]   rem_reg, rem_next;
    logic [15:0]      quo_reg, quo_next;
    logic [4:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DIV_W+1:0] trial;

    // Restoring remainder, one dividend bit a cycle
    always_comb
    begin
        trial     = {rem_reg, quo_reg[15]};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = 5'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {2'b00, divisor})
            begin
                trial = trial - {2'b00, divisor};
            end
            rem_next = trial[DIV_W:0];
            quo_next = {quo_reg[14:0], 1'b0};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd15)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg[DIV_W-1:0];

endmodule

>>> rtl/set_assoc_cache_tag_controller_top.sv
// An access runs from acceptance through the scan, decide and write states to its result; a
//   random victim adds a pass through the remainder unit (LFSR modulo ways).
// Throughput: one transaction at a time; the single read port of the line store reads one
//   way per cycle, and a dirty count reads 2^set_bits * ways_in_use lines.
// Reset: asynchronous, active low; a clearing pass over all MAX_SETS*MAX_WAYS lines (2048 by
//   default) zeroes the line store, and no input transaction is taken until it ends.
module set_assoc_cache_tag_controller_top #(
    parameter int MAX_WAYS = sacc_pkg::MAX_WAYS_DEF,
    parameter int MAX_SETS = sacc_pkg::MAX_SETS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [4:0]  cfg_data,
    // input transactions
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [31:0] address,
    // result transactions
    output logic        out_valid,
    input  logic        out_ready,
    output logic        hit,
    output logic [2:0]  way,
    output logic        fill_read,
    output logic [1:0]  mem_writes,
    output logic [11:0] dirty_count
);

    localparam int LINES   = MAX_SETS * MAX_WAYS;
    localparam int LINE_AW = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WAYS_W  = $clog2(MAX_WAYS + 1);
    localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int SB_MAX  = $clog2(MAX_SETS + 1) - 1;   // floor log2
    localparam int LW      = $bits(sacc_pkg::line_t);

    // sequencer states
    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_MOD    = 3'd4;
    localparam logic [2:0] S_WRITE  = 3'd5;
    localparam logic [2:0] S_FLUSH  = 3'd6;

    logic [2:0] state_reg, state_next;

    // configuration registers
    logic       wp_reg, rp_reg;
    logic [4:0] off_cfg_reg;
    logic [3:0] sb_cfg_reg;
    logic [3:0] ways_cfg_reg;

    // effective geometry
    logic [4:0]        off_eff;
    logic [3:0]        sb_eff;
    logic [WAYS_W-1:0] ways_eff;

    // per-transaction context
    logic                      is_write_reg;
    logic [SET_W-1:0]          set_reg;
    logic [sacc_pkg::TAG_W-1:0] tag_reg;
    logic [3:0]                sb_reg;
    logic [WAYS_W-1:0]         ways_reg;

    // scan bookkeeping
    logic [WAYS_W-1:0]         iss_reg;
    logic                      pend_reg;
    logic [WAY_W-1:0]          pend_way_reg;
    logic                      hit_reg, free_reg;
    logic [WAY_W-1:0]          hit_way_reg, free_way_reg, lru_way_reg, sel_way_reg;
    logic [sacc_pkg::AGE_W-1:0] oldest_reg;
    logic [MAX_WAYS-1:0]       dvec_reg;

    // flush bookkeeping
    logic [SET_W:0]            fs_reg;
    logic [WAYS_W-1:0]         fw_reg;
    logic [sacc_pkg::CNT_W-1:0] cnt_reg;
    logic [SET_W:0]            sets_in_use;

    logic [LINE_AW-1:0]        clr_reg;
    logic [sacc_pkg::AGE_W-1:0] age_reg;
    logic [15:0]               lfsr_reg;

    // RAM ports
    logic                 ram_we, ram_re;
    logic [LINE_AW-1:0]   ram_waddr, ram_raddr;
    sacc_pkg::line_t      ram_wline, ram_rline;
    logic [LW-1:0]        ram_rdata;

    // remainder unit
    logic                 mod_start, mod_done;
    logic [WAYS_W-1:0]    mod_rem;

    // address split
    logic [31:0]          addr_m;
    logic [31:0]          set_shift;
    logic [SET_W-1:0]     set_mask;

    // result registers
    logic                 out_valid_reg;
    logic                 hit_out_reg, fill_out_reg;
    logic [2:0]           way_out_reg;
    logic [1:0]           wr_out_reg;
    logic [11:0]          cnt_out_reg;

    // write stage values
    logic                 sel_dirty;
    logic                 wt_write;
    logic                 evict_dirty;
    logic                 line_dirty_new;

    logic                 scan_issue, flush_issue;

    // ---------------------------------------------------------------
    // Clamp the configuration into the ranges the hardware supports
    // ---------------------------------------------------------------
    always_comb
    begin
        off_eff = (off_cfg_reg > sacc_pkg::MAX_OFFSET_BITS) ? sacc_pkg::MAX_OFFSET_BITS
                                                             : off_cfg_reg;
        sb_eff  = (int'(sb_cfg_reg) > SB_MAX) ? 4'(SB_MAX) : sb_cfg_reg;
        if (ways_cfg_reg == 4'd0)
        begin
            ways_eff = WAYS_W'(1);
        end
        else if (int'(ways_cfg_reg) > MAX_WAYS)
        begin
            ways_eff = WAYS_W'(MAX_WAYS);
        end
        else
        begin
            ways_eff = WAYS_W'(ways_cfg_reg);
        end
    end

    // Split the byte address into set index and tag
    assign addr_m    = 32'(64'(address) & ((64'd1 << sacc_pkg::ADDR_BITS) - 64'd1));
    assign set_shift = addr_m >> off_eff;
    assign set_mask  = SET_W'((32'd1 << sb_eff) - 32'd1);

    assign sets_in_use = (SET_W + 1)'(1) << sb_reg;

    // Configuration writes land immediately
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg       <= 1'b0;
            rp_reg       <= 1'b0;
            off_cfg_reg  <= 5'd4;
            sb_cfg_reg   <= 4'd5;
            ways_cfg_reg <= 4'd4;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sacc_pkg::CFG_WRITE_POLICY:   wp_reg       <= cfg_data[0];
                sacc_pkg::CFG_REPLACE_POLICY: rp_reg       <= cfg_data[0];
                sacc_pkg::CFG_OFFSET_BITS:    off_cfg_reg  <= cfg_data;
                sacc_pkg::CFG_SET_BITS:       sb_cfg_reg   <= cfg_data[3:0];
                sacc_pkg::CFG_WAYS_IN_USE:    ways_cfg_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Line store
    // ---------------------------------------------------------------
    assign scan_issue  = (state_reg == S_SCAN) && (iss_reg < ways_reg);
    assign flush_issue = (state_reg == S_FLUSH) && (fs_reg < sets_in_use);
    assign ram_re      = scan_issue || flush_issue;

    always_comb
    begin
        if (state_reg == S_FLUSH)
        begin
            ram_raddr = LINE_AW'(fs_reg[SET_W-1:0]) * LINE_AW'(MAX_WAYS) + LINE_AW'(fw_reg);
        end
        else
        begin
            ram_raddr = LINE_AW'(set_reg) * LINE_AW'(MAX_WAYS) + LINE_AW'(iss_reg);
        end
    end

    assign sel_dirty      = dvec_reg[sel_way_reg];
    assign wt_write       = is_write_reg && !wp_reg;
    assign evict_dirty    = !hit_reg && !free_reg && sel_dirty;
    assign line_dirty_new = hit_reg ? (sel_dirty || (is_write_reg && wp_reg))
                                    : (is_write_reg && wp_reg);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = LINE_AW'(set_reg) * LINE_AW'(MAX_WAYS) + LINE_AW'(sel_way_reg);
        ram_wline = '0;
        if (state_reg == S_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
        end
        else if (state_reg == S_WRITE)
        begin
            ram_we          = 1'b1;
            ram_wline.valid = 1'b1;
            ram_wline.dirty = line_dirty_new;
            ram_wline.tag   = tag_reg;
            ram_wline.age   = age_reg + 64'd1;
        end
    end

    sacc_ram #(
        .WIDTH (LW),
        .DEPTH (1 << LINE_AW)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wline),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ram_rline = ram_rdata;

    // Random victim: LFSR value modulo the ways in use
    assign mod_start = (state_reg == S_DECIDE) && !hit_reg && !free_reg && rp_reg;

    sacc_mod #(
        .DIV_W (WAYS_W)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (sacc_pkg::lfsr_next(lfsr_reg)),
        .divisor  (ways_reg),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    assign in_ready = (state_reg == S_IDLE) && !out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == LINE_AW'(LINES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    if (func == sacc_pkg::FUNC_FLUSH)
                    begin
                        state_next = S_FLUSH;
                    end
                    else if (func == sacc_pkg::FUNC_READ || func == sacc_pkg::FUNC_WRITE)
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (!scan_issue && !pend_reg)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next = mod_start ? S_MOD : S_WRITE;
            end
            S_MOD:
            begin
                if (mod_done)
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                state_next = S_IDLE;
            end
            S_FLUSH:
            begin
                if (!flush_issue && !pend_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            age_reg       <= '0;
            lfsr_reg      <= sacc_pkg::LFSR_SEED;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= ram_re;
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + LINE_AW'(1);
            end
            if (mod_start)
            begin
                lfsr_reg <= sacc_pkg::lfsr_next(lfsr_reg);
            end
            if (state_reg == S_WRITE)
            begin
                age_reg <= age_reg + 64'd1;
            end
            // drop the result once taken, raise it when a transaction completes
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if ((state_reg == S_IDLE && in_valid && in_ready
                    && func != sacc_pkg::FUNC_READ && func != sacc_pkg::FUNC_WRITE
                    && func != sacc_pkg::FUNC_FLUSH)
                || state_reg == S_WRITE
                || (state_reg == S_FLUSH && state_next == S_IDLE))
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid && in_ready)
        begin
            is_write_reg <= (func == sacc_pkg::FUNC_WRITE);
            set_reg      <= set_shift[SET_W-1:0] & set_mask;
            tag_reg      <= sacc_pkg::TAG_W'(addr_m >> (6'(off_eff) + 6'(sb_eff)));
            sb_reg       <= sb_eff;
            ways_reg     <= ways_eff;
            iss_reg      <= '0;
            hit_reg      <= 1'b0;
            free_reg     <= 1'b0;
            fs_reg       <= '0;
            fw_reg       <= '0;
            cnt_reg      <= '0;
            hit_out_reg  <= 1'b0;
            fill_out_reg <= 1'b0;
            way_out_reg  <= 3'd0;
            wr_out_reg   <= 2'd0;
            cnt_out_reg  <= 12'd0;
        end

        if (scan_issue)
        begin
            iss_reg <= iss_reg + WAYS_W'(1);
        end
        pend_way_reg <= WAY_W'(iss_reg);

        // Consume a way read back from the store
        if (state_reg == S_SCAN && pend_reg)
        begin
            dvec_reg[pend_way_reg] <= ram_rline.dirty;
            if (ram_rline.valid && ram_rline.tag == tag_reg && !hit_reg)
            begin
                hit_reg     <= 1'b1;
                hit_way_reg <= pend_way_reg;
            end
            if (!ram_rline.valid && !free_reg)
            begin
                free_reg     <= 1'b1;
                free_way_reg <= pend_way_reg;
            end
            if (pend_way_reg == '0 || ram_rline.age < oldest_reg)
            begin
                oldest_reg  <= ram_rline.age;
                lru_way_reg <= pend_way_reg;
            end
        end

        if (state_reg == S_DECIDE)
        begin
            if (hit_reg)
            begin
                sel_way_reg <= hit_way_reg;
            end
            else if (free_reg)
            begin
                sel_way_reg <= free_way_reg;
            end
            else
            begin
                sel_way_reg <= lru_way_reg;
            end
        end

        if (state_reg == S_MOD && mod_done)
        begin
            sel_way_reg <= WAY_W'(mod_rem);
        end

        if (state_reg == S_WRITE)
        begin
            hit_out_reg  <= hit_reg;
            fill_out_reg <= !hit_reg;
            way_out_reg  <= 3'(sel_way_reg);
            wr_out_reg   <= {1'b0, evict_dirty} + {1'b0, wt_write};
        end

        // Dirty count walk over sets and ways in use
        if (flush_issue)
        begin
            if (fw_reg == ways_reg - WAYS_W'(1))
            begin
                fw_reg <= '0;
                fs_reg <= fs_reg + (SET_W + 1)'(1);
            end
            else
            begin
                fw_reg <= fw_reg + WAYS_W'(1);
            end
        end
        if (state_reg == S_FLUSH && pend_reg && ram_rline.valid && ram_rline.dirty)
        begin
            cnt_reg <= cnt_reg + 12'd1;
        end
        if (state_reg == S_FLUSH && state_next == S_IDLE)
        begin
            cnt_out_reg <= cnt_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign hit         = hit_out_reg;
    assign way         = way_out_reg;
    assign fill_read   = fill_out_reg;
    assign mem_writes  = wr_out_reg;
    assign dirty_count = cnt_out_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> !out_valid_reg)
        else $error("result raised during clearing pass");

    a_victim_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WRITE |-> WAYS_W'(sel_way_reg) < ways_reg)
        else $error("selected way beyond ways in use");

    a_hit_no_fill: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(hit_out_reg && fill_out_reg))
        else $error("hit and fill reported together");

    a_age_advance: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WRITE |=> age_reg == $past(age_reg) + 64'd1)
        else $error("age stamp did not advance on line write");

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int NWAYS = sacc_pkg::MAX_WAYS_DEF;
    localparam int NSETS = sacc_pkg::MAX_SETS_DEF;
    localparam int NLINES = NWAYS * NSETS;
    localparam int CYCLE_LIMIT = 1500000;
    localparam logic [1:0] FUNC_NONE = 2'd3;

    typedef struct packed {
        logic        hit;
        logic [2:0]  way;
        logic        fill_read;
        logic [1:0]  mem_writes;
        logic [11:0] dirty_count;
    } outcome_t;

    // One row of the directed table; chk marks rows with a hand-typed outcome
    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] addr;
        logic        chk;
        outcome_t    res;
    } vec_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [4:0]  cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  func;
    logic [31:0] address;
    logic        out_valid;
    logic        out_ready;
    logic        hit;
    logic [2:0]  way;
    logic        fill_read;
    logic [1:0]  mem_writes;
    logic [11:0] dirty_count;

    set_assoc_cache_tag_controller_top dut (.*);

    // Shadow copy of the tag store and controller registers
    logic        sh_valid [NLINES];
    logic        sh_dirty [NLINES];
    logic [31:0] sh_tag   [NLINES];
    logic [63:0] sh_age   [NLINES];
    logic [63:0] stamp;
    logic [15:0] victim_sr;
    logic        wr_back;
    logic        rnd_victim;
    logic [4:0]  off_reg;
    logic [3:0]  sets_reg;
    logic [3:0]  ways_reg;

    outcome_t expected_q[$];
    int       errors;
    int       accesses;
    int       flushes;
    int       cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Abort on a hang; allows the clearing pass plus long flush counts
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic int used_set_bits();
        int n;
        n = 0;
        while (n < sets_reg && (2 << n) <= NSETS)
            n++;
        return n;
    endfunction

    function automatic int used_ways();
        if (ways_reg == 0)
            return 1;
        if (ways_reg > NWAYS)
            return NWAYS;
        return ways_reg;
    endfunction

    // Compute the outcome of one transaction and advance the shadow state
    function automatic outcome_t cache_lookup(logic [1:0] f, logic [31:0] a);
        outcome_t   r;
        int         off, sb, nw, set, base, w, cnt;
        logic [31:0] tg;
        logic [63:0] oldest;
        logic        found, is_wr;
        logic [15:0] fb;
        r = '0;
        off = (off_reg > sacc_pkg::MAX_OFFSET_BITS) ? int'(sacc_pkg::MAX_OFFSET_BITS)
                                                    : int'(off_reg);
        sb = used_set_bits();
        nw = used_ways();
        if (f == sacc_pkg::FUNC_FLUSH)
        begin
            cnt = 0;
            for (int s = 0; s < (1 << sb); s++)
                for (int i = 0; i < nw; i++)
                    if (sh_valid[s*NWAYS+i] && sh_dirty[s*NWAYS+i])
                        cnt++;
            r.dirty_count = cnt[11:0];
            return r;
        end
        if (f == FUNC_NONE)
            return r;
        set = int'((64'(a) >> off) & ((64'd1 << sb) - 1));
        tg = 32'(64'(a) >> (off + sb));
        base = set * NWAYS;
        is_wr = (f == sacc_pkg::FUNC_WRITE);
        found = 1'b0;
        w = 0;
        for (int i = 0; i < nw; i++)
            if (!found && sh_valid[base+i] && sh_tag[base+i] == tg)
            begin
                found = 1'b1;
                w = i;
            end
        if (found)
        begin
            r.hit = 1'b1;
        end
        else
        begin
            r.fill_read = 1'b1;
            found = 1'b0;
            for (int i = 0; i < nw; i++)
                if (!found && !sh_valid[base+i])
                begin
                    found = 1'b1;
                    w = i;
                end
            if (!found)
            begin
                if (!rnd_victim)
                begin
                    oldest = sh_age[base];
                    w = 0;
                    for (int i = 1; i < nw; i++)
                        if (sh_age[base+i] < oldest)
                        begin
                            oldest = sh_age[base+i];
                            w = i;
                        end
                end
                else
                begin
                    fb = victim_sr;
                    victim_sr = {fb[0] ^ fb[2] ^ fb[3] ^ fb[5], fb[15:1]};
                    w = int'(victim_sr) % nw;
                end
                if (sh_dirty[base+w])
                    r.mem_writes++;
            end
            sh_valid[base+w] = 1'b1;
            sh_tag[base+w] = tg;
            sh_dirty[base+w] = 1'b0;
        end
        stamp++;
        sh_age[base+w] = stamp;
        if (is_wr)
        begin
            if (wr_back)
                sh_dirty[base+w] = 1'b1;
            else
                r.mem_writes++;
        end
        r.way = w[2:0];
        return r;
    endfunction

    // Compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin
        outcome_t got, want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{hit, way, fill_read, mem_writes, dirty_count};
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result %p", $time, got);
                errors++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (got.hit !== want.hit)
                begin
                    $display("%0t: hit exp %0d got %0d", $time, want.hit, got.hit);
                    errors++;
                end
                if (got.way !== want.way)
                begin
                    $display("%0t: way exp %0d got %0d", $time, want.way, got.way);
                    errors++;
                end
                if (got.fill_read !== want.fill_read)
                begin
                    $display("%0t: fill_read exp %0d got %0d", $time,
                             want.fill_read, got.fill_read);
                    errors++;
                end
                if (got.mem_writes !== want.mem_writes)
                begin
                    $display("%0t: mem_writes exp %0d got %0d", $time,
                             want.mem_writes, got.mem_writes);
                    errors++;
                end
                if (got.dirty_count !== want.dirty_count)
                begin
                    $display("%0t: dirty_count exp %0d got %0d", $time,
                             want.dirty_count, got.dirty_count);
                    errors++;
                end
            end
        end
    end

    // Receiver: draw a stall per result, with calm stretches now and then
    logic sink_calm;
    int   sink_wait;
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            sink_wait = $urandom_range(0, 17);
        end
        else
        begin
            if ($urandom_range(0, 99) < 2)
                sink_calm = ~sink_calm;
            if (out_ready && out_valid)
            begin
                sink_wait = sink_calm ? 0 : $urandom_range(0, 17);
                out_ready <= (sink_wait == 0);
            end
            else if (!out_ready)
            begin
                if (sink_wait > 0)
                    sink_wait--;
                out_ready <= (sink_wait == 0);
            end
        end
    end

    // Write one register while idle; mirror it in the shadow state
    task automatic write_reg(logic [2:0] idx, logic [4:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            sacc_pkg::CFG_WRITE_POLICY:   wr_back = val[0];
            sacc_pkg::CFG_REPLACE_POLICY: rnd_victim = val[0];
            sacc_pkg::CFG_OFFSET_BITS:    off_reg = val;
            sacc_pkg::CFG_SET_BITS:       sets_reg = val[3:0];
            sacc_pkg::CFG_WAYS_IN_USE:    ways_reg = val[3:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Drop the input, let every expected result arrive, then the longest flush latency
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (NLINES + 40) @(posedge clk);
    endtask

    // Offer one transaction after a random lead gap (none when quiet); hold it until accepted
    task automatic send_txn(logic [1:0] f, logic [31:0] a, logic quiet, output outcome_t res);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 17);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        address <= a;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        res = cache_lookup(f, a);
        expected_q.push_back(res);
        if (f == sacc_pkg::FUNC_FLUSH)
            flushes++;
        else
            accesses++;
    endtask

    // Addresses mostly drawn from a small pool of tags and sets so hits and evictions occur
    function automatic logic [31:0] pick_addr();
        int off, sb;
        logic [31:0] a;
        off = (off_reg > sacc_pkg::MAX_OFFSET_BITS) ? int'(sacc_pkg::MAX_OFFSET_BITS)
                                                    : int'(off_reg);
        sb = used_set_bits();
        if ($urandom_range(0, 9) == 0)
            return $urandom();
        a = $urandom_range(0, 11);
        a = (a << sb) | $urandom_range(0, 3);
        a = (a << off) | ($urandom() & ((32'd1 << off) - 1));
        if ($urandom_range(0, 7) == 0)
            a = a ^ 32'hFFFF_0000;
        return a;
    endfunction

    vec_t table_rows[] = '{
        // cold misses and a hit fill ways 0..3 of set 0 at reset geometry; then a dirty count and an unknown code
        '{sacc_pkg::FUNC_READ,  32'h0000_0000, 1'b1, '{1'b0, 3'd0, 1'b1, 2'd0, 12'd0}},
        '{sacc_pkg::FUNC_READ,  32'h0000_000F, 1'b1, '{1'b1, 3'd0, 1'b0, 2'd0, 12'd0}},
        '{sacc_pkg::FUNC_WRITE, 32'h0000_0200, 1'b1, '{1'b0, 3'd1, 1'b1, 2'd1, 12'd0}},
        '{sacc_pkg::FUNC_READ,  32'h0000_0400, 1'b1, '{1'b0, 3'd2, 1'b1, 2'd0, 12'd0}},
        '{sacc_pkg::FUNC_READ,  32'hFFFF_FC00, 1'b1, '{1'b0, 3'd3, 1'b1, 2'd0, 12'd0}},
        '{sacc_pkg::FUNC_FLUSH, 32'hFFFF_FFFF, 1'b1, '{1'b0, 3'd0, 1'b0, 2'd0, 12'd0}},
        '{FUNC_NONE,            32'hFFFF_FFFF, 1'b1, '{1'b0, 3'd0, 1'b0, 2'd0, 12'd0}},
        // set 0 full: least recent evictions, mixed with accesses to other sets
        '{sacc_pkg::FUNC_READ,  32'h0000_0600, 1'b0, '0},
        '{sacc_pkg::FUNC_WRITE, 32'hFFFF_FFFF, 1'b0, '0},
        '{sacc_pkg::FUNC_WRITE, 32'hFFFF_FFF0, 1'b0, '0},
        '{sacc_pkg::FUNC_READ,  32'h8000_0000, 1'b0, '0},
        '{sacc_pkg::FUNC_READ,  32'h0000_0010, 1'b0, '0}
    };

    initial
    begin
        outcome_t r;
        int phase;
        logic [4:0] cfg_pick [5];
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = sacc_pkg::CFG_WRITE_POLICY;
        cfg_data = '0;
        in_valid = 1'b0;
        func = sacc_pkg::FUNC_READ;
        address = '0;
        errors = 0;
        accesses = 0;
        flushes = 0;
        cycles = 0;
        sink_calm = 1'b0;
        for (int i = 0; i < NLINES; i++)
        begin
            sh_valid[i] = 1'b0;
            sh_dirty[i] = 1'b0;
            sh_tag[i] = '0;
            sh_age[i] = '0;
        end
        stamp = '0;
        victim_sr = sacc_pkg::LFSR_SEED;
        wr_back = 1'b0;
        rnd_victim = 1'b0;
        off_reg = 5'd4;
        sets_reg = 4'd5;
        ways_reg = 4'd4;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows: typed outcomes where obvious, predictor otherwise
        foreach (table_rows[i])
        begin
            send_txn(table_rows[i].func, table_rows[i].addr, 1'b0, r);
            if (table_rows[i].chk && r !== table_rows[i].res)
            begin
                $display("%0t: row %0d exp %p got %p", $time, i, table_rows[i].res, r);
                errors++;
            end
        end
        drain();

        // Write-back with random victims at the largest, then the smallest geometry, dirty counts among the writes
        write_reg(sacc_pkg::CFG_WRITE_POLICY, 5'd1);
        write_reg(sacc_pkg::CFG_REPLACE_POLICY, 5'd1);
        write_reg(sacc_pkg::CFG_OFFSET_BITS, 5'd31);
        write_reg(sacc_pkg::CFG_SET_BITS, 5'd15);
        write_reg(sacc_pkg::CFG_WAYS_IN_USE, 5'd15);
        for (int i = 0; i < 12; i++)
            send_txn((i % 4 == 3) ? sacc_pkg::FUNC_FLUSH : sacc_pkg::FUNC_WRITE,
                     {i[3:0], 28'h0} ^ (i[0] ? 32'hFFFF_FFFF : 32'h0), 1'b0, r);
        drain();
        write_reg(sacc_pkg::CFG_OFFSET_BITS, 5'd0);
        write_reg(sacc_pkg::CFG_SET_BITS, 5'd0);
        write_reg(sacc_pkg::CFG_WAYS_IN_USE, 5'd0);
        for (int i = 0; i < 6; i++)
            send_txn(i[0] ? sacc_pkg::FUNC_WRITE : sacc_pkg::FUNC_READ,
                     i * 32'h5555_5555, 1'b0, r);
        drain();

        // Random phases, each under a fresh register setting
        for (phase = 0; phase < 9; phase++)
        begin
            cfg_pick[0] = 5'($urandom_range(0, 1));
            cfg_pick[1] = 5'($urandom_range(0, 1));
            cfg_pick[2] = (phase == 8) ? 5'd24 : 5'($urandom_range(0, 31));
            cfg_pick[3] = (phase == 8) ? 5'd8 : 5'($urandom_range(0, 5));
            cfg_pick[4] = (phase == 7) ? 5'd1 : 5'($urandom_range(0, 9));
            for (int k = 0; k < 5; k++)
                write_reg(k[2:0], cfg_pick[k]);
            for (int i = 0; i < 50; i++)
            begin
                int roll;
                logic [1:0] f;
                roll = $urandom_range(0, 99);
                f = (roll < 50) ? sacc_pkg::FUNC_READ : (roll < 93) ? sacc_pkg::FUNC_WRITE :
                    (roll < 97) ? sacc_pkg::FUNC_FLUSH : FUNC_NONE;
                send_txn(f, pick_addr(), (phase % 3) == 2 && i < 20, r);
                // hold off the sender until everything outstanding has returned
                if (i == 25 && phase == 4)
                begin
                    in_valid <= 1'b0;
                    while (expected_q.size() != 0)
                        @(posedge clk);
                end
            end
            drain();
        end

        $display("Covered %0d accesses and %0d dirty counts over 12 register settings.",
                 accesses, flushes);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
